// File: design/cfq_pkg.sv
`default_nettype none

package cfq_pkg;

	// storage and word size
	localparam int MaxDepth  = 16;
	localparam int WordWidth = 32;
	localparam int CntW      = $clog2(MaxDepth + 1);
	localparam int CapW      = 5;
	localparam int CapReset  = 10;

	typedef logic signed [WordWidth-1:0] word_t;

	localparam word_t MostNeg = {1'b1, {(WordWidth - 1){1'b0}}};

	typedef enum logic [1:0] {
		OP_ENQ       = 2'd0,
		OP_DEQ       = 2'd1,
		OP_PEEK_HEAD = 2'd2,
		OP_PEEK_TAIL = 2'd3
	} op_t;

	typedef struct packed {
		op_t   operation;
		word_t item_value;
	} req_t;

	typedef struct packed {
		word_t           data_value;
		logic            was_empty;
		logic            was_dropped;
		logic [CntW-1:0] occupancy;
		logic            is_full;
		logic            is_empty;
	} rsp_t;

	// per-cell control
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: design/cfq_cell.sv
`default_nettype none

module cfq_cell (
	input  wire logic              clk,
	input  wire cfq_pkg::cell_ctl_t ctl,
	input  wire cfq_pkg::word_t    load_data,
	input  wire cfq_pkg::word_t    next_data,
	output cfq_pkg::word_t         data
);
	import cfq_pkg::*;

	word_t data_q;

	// load a new tail word, or take the neighbor's word on a pop
	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			data_q <= load_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// File: design/circular_fifo_queue_core.sv
`default_nettype none

// circular fifo queue of signed words, built as a row of shifting cells
// request channel (req_valid / req_ready / req): one operation per transfer,
//   enqueue, dequeue, peek at the head or peek at the newest entry
// response channel (rsp_valid / rsp_ready / rsp): exactly one response per
//   request, in order, with the word read, empty / dropped flags and the
//   occupancy, full and empty status after the operation
// cell 0 always holds the head; a dequeue shifts every cell one place
//   toward the head in the same cycle, an enqueue loads the cell whose
//   position equals the occupancy, and the newest word is kept in its own
//   register for tail peeks
// the response is registered and appears in the cycle after the request transfer
// throughput: one request per cycle while responses are taken; the
//   single response register sets that figure
// if the receiver stalls, the response register holds and req_ready drops
//   until it is taken
// reset empties the queue and sets the capacity to 10; a write on
//   cfg_wen sets the capacity (0 acts as 1, above 16 acts as 16) and
//   empties the queue; write it only while no request is in flight
module circular_fifo_queue_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_ready,
	input  wire cfq_pkg::req_t           req,
	output logic                         rsp_valid,
	input  wire logic                    rsp_ready,
	output cfq_pkg::rsp_t                rsp,
	input  wire logic                    cfg_wen,
	input  wire logic [cfq_pkg::CapW-1:0] cfg_wdata
);
	import cfq_pkg::*;

	logic [CapW-1:0] cap_q;
	logic [CntW-1:0] count_q;
	word_t           tail_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic [CntW-1:0] cap_eff;
	logic            accept;
	logic            full;
	logic            empty;
	logic            do_load;
	logic            do_shift;
	logic [CntW-1:0] next_count;
	rsp_t            rsp_d;

	word_t     cell_data [MaxDepth];
	word_t     cell_next [MaxDepth];
	cell_ctl_t cell_ctl  [MaxDepth];

	// clamp the capacity register into the usable range
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CntW'(1);
		end else if (int'(cap_q) > MaxDepth) begin
			cap_eff = CntW'(MaxDepth);
		end else begin
			cap_eff = CntW'(cap_q);
		end
	end

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = count_q >= cap_eff;
	assign empty     = count_q == '0;

	// operation decode and response build
	always_comb begin
		do_load          = 1'b0;
		do_shift         = 1'b0;
		next_count       = count_q;
		rsp_d            = '0;
		unique case (req.operation)
			OP_ENQ: begin
				if (full) begin
					rsp_d.was_dropped = 1'b1;
				end else begin
					do_load    = 1'b1;
					next_count = count_q + CntW'(1);
				end
			end
			OP_DEQ: begin
				if (empty) begin
					rsp_d.data_value = MostNeg;
					rsp_d.was_empty  = 1'b1;
				end else begin
					rsp_d.data_value = cell_data[0];
					do_shift         = 1'b1;
					next_count       = count_q - CntW'(1);
				end
			end
			OP_PEEK_HEAD: begin
				if (empty) begin
					rsp_d.data_value = MostNeg;
					rsp_d.was_empty  = 1'b1;
				end else begin
					rsp_d.data_value = cell_data[0];
				end
			end
			OP_PEEK_TAIL: begin
				if (empty) begin
					rsp_d.data_value = MostNeg;
					rsp_d.was_empty  = 1'b1;
				end else begin
					rsp_d.data_value = tail_q;
				end
			end
			default: begin
				rsp_d.was_empty = 1'b0;
			end
		endcase
		rsp_d.occupancy = next_count;
		rsp_d.is_full   = next_count == cap_eff;
		rsp_d.is_empty  = next_count == '0;
	end

	// row of cells; the last one has no right-hand neighbor
	for (genvar i = 0; i < MaxDepth; i++) begin : g_cell
		if (i == MaxDepth - 1) begin : g_last
			assign cell_next[i] = '0;
		end else begin : g_mid
			assign cell_next[i] = cell_data[i+1];
		end

		assign cell_ctl[i].shift = accept && do_shift;
		assign cell_ctl[i].load  = accept && do_load && (count_q == CntW'(i));

		cfq_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.load_data (req.item_value),
			.next_data (cell_next[i]),
			.data      (cell_data[i])
		);
	end

	// occupancy and capacity; a capacity write empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CapW'(CapReset);
			count_q <= '0;
		end else if (cfg_wen) begin
			cap_q   <= cfg_wdata;
			count_q <= '0;
		end else if (accept) begin
			count_q <= next_count;
		end
	end

	// newest word, for tail peeks
	always_ff @(posedge clk) begin
		if (accept && do_load) begin
			tail_q <= req.item_value;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// occupancy never passes the capacity in use
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff)
		else $error("occupancy above capacity");

	// an accepted enqueue into a non-full queue grows the occupancy by one
	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_wen && req.operation == OP_ENQ && !full
		|=> count_q == $past(count_q) + CntW'(1))
		else $error("enqueue did not add an entry");

	// a read on an empty queue reports it
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.operation != OP_ENQ && empty
		|=> rsp_q.was_empty && rsp_q.data_value == MostNeg)
		else $error("empty read not flagged");

	// a stalled response blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import cfq_pkg::*;

	// clock, reset and every block input start at known values
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	req_t req = '0;
	logic rsp_ready = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CapW-1:0] cfg_wdata = '0;

	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	circular_fifo_queue_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the queue, advanced once per request transfer
	word_t m_store [MaxDepth];
	int m_head;
	int m_tail;
	int m_count;
	logic [CapW-1:0] m_cap;

	// responses predicted but not yet seen on the response channel
	rsp_t pending_rsp [$];
	int errors = 0;

	// no_idle turns off random gaps on both channels
	bit no_idle = 1'b0;
	// a long receiver hold-off is requested here and counted down in the receiver
	int hold_request = 0;
	int hold_left = 0;

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#1_000_000;
		$display("circular_fifo_queue_core test failed");
		$finish;
	end

	// capacity register as the queue sees it: 0 acts as 1, above the depth acts as the depth
	function automatic int eff_capacity();
		if (m_cap == 0)
			return 1;
		if (m_cap > MaxDepth)
			return MaxDepth;
		return int'(m_cap);
	endfunction

	// index wrap by compare-and-reset at the capacity
	function automatic int wrap_next(int idx);
		return (idx + 1 >= eff_capacity()) ? 0 : idx + 1;
	endfunction

	function automatic void clear_queue_model();
		m_head = 0;
		m_tail = eff_capacity() - 1;
		m_count = 0;
	endfunction

	// applies one request to the shadow queue and returns the response it must produce
	function automatic rsp_t fifo_predict(req_t r);
		rsp_t res;
		int cap;
		res = '0;
		cap = eff_capacity();
		if (r.operation == OP_ENQ) begin
			// full queue drops the word and leaves the state alone
			if (m_count >= cap) begin
				res.was_dropped = 1'b1;
			end else begin
				m_tail = wrap_next(m_tail);
				m_store[m_tail] = r.item_value;
				m_count++;
			end
		end else if (m_count == 0) begin
			// any read on an empty queue
			res.data_value = MostNeg;
			res.was_empty = 1'b1;
		end else begin
			case (r.operation)
				OP_DEQ: begin
					res.data_value = m_store[m_head];
					m_head = wrap_next(m_head);
					m_count--;
				end
				OP_PEEK_HEAD: begin
					res.data_value = m_store[m_head];
				end
				default: begin
					res.data_value = m_store[m_tail];
				end
			endcase
		end
		res.occupancy = CntW'(m_count);
		res.is_full = (m_count == cap);
		res.is_empty = (m_count == 0);
		return res;
	endfunction

	// random word with the edge values mixed in
	function automatic word_t random_word();
		case ($urandom_range(15))
			0: return MostNeg;
			1: return ~MostNeg;
			2: return '0;
			3: return '1;
			default: return word_t'($urandom());
		endcase
	endfunction

	// receiver: random stalls, idle-free stretches, and the long hold-off on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (no_idle) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= 14);
		end
	end

	task automatic check_field(string name, logic [WordWidth-1:0] want,
			logic [WordWidth-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// every response transfer is matched against the oldest prediction
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: response with nothing pending, expected none, actual %p",
					$time, rsp);
			end else begin
				want = pending_rsp.pop_front();
				check_field("data_value", want.data_value, rsp.data_value);
				check_field("was_empty", want.was_empty, rsp.was_empty);
				check_field("was_dropped", want.was_dropped, rsp.was_dropped);
				check_field("occupancy", want.occupancy, rsp.occupancy);
				check_field("is_full", want.is_full, rsp.is_full);
				check_field("is_empty", want.is_empty, rsp.is_empty);
			end
		end
	end

	// offers one request and holds it until the transfer; valid stays up
	// afterwards unless a gap is taken, so back-to-back requests need no toggle
	task automatic send_request(op_t op, word_t value);
		req_t r;
		r.operation = op;
		r.item_value = value;
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		pending_rsp.push_back(fifo_predict(r));
		if (!no_idle && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// sender stops and waits for every outstanding response
	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// capacity write only with the queue idle; the write also empties the queue
	task automatic set_capacity(logic [CapW-1:0] value);
		wait_quiet();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		m_cap = value;
		clear_queue_model();
		cfg_wen <= 1'b0;
	endtask

	// every read kind on the empty queue right after reset
	task automatic test_empty_reads();
		send_request(OP_PEEK_HEAD, random_word());
		send_request(OP_PEEK_TAIL, random_word());
		send_request(OP_DEQ, random_word());
	endtask

	// extreme words go in and come back out in order
	task automatic test_word_extremes();
		send_request(OP_ENQ, ~MostNeg);
		send_request(OP_ENQ, MostNeg);
		send_request(OP_ENQ, '0);
		send_request(OP_ENQ, '1);
		send_request(OP_PEEK_HEAD, random_word());
		send_request(OP_PEEK_TAIL, random_word());
		repeat (4) send_request(OP_DEQ, random_word());
	endtask

	// enqueue into a full queue is dropped; one entry is left behind on purpose
	task automatic test_full_drop();
		set_capacity(CapW'(2));
		send_request(OP_ENQ, word_t'(32'sd11));
		send_request(OP_ENQ, word_t'(32'sd22));
		send_request(OP_ENQ, word_t'(32'sd33));
		send_request(OP_PEEK_TAIL, random_word());
		send_request(OP_DEQ, random_word());
	endtask

	// capacity zero acts as one, and the write clears the leftover entry
	task automatic test_capacity_clamp();
		set_capacity(CapW'(0));
		send_request(OP_DEQ, random_word());
		send_request(OP_ENQ, random_word());
		send_request(OP_ENQ, random_word());
		send_request(OP_PEEK_HEAD, random_word());
		send_request(OP_PEEK_TAIL, random_word());
	endtask

	// random traffic whose enqueue share swings so the queue keeps hitting full and empty
	task automatic test_random_traffic(logic [CapW-1:0] cap, int n_items);
		int fill_pct;
		op_t op;
		fill_pct = $urandom_range(1) ? 75 : 25;
		set_capacity(cap);
		for (int i = 0; i < n_items; i++) begin
			if (i % 24 == 23)
				fill_pct = 100 - fill_pct;
			if ($urandom_range(99) < fill_pct) begin
				op = OP_ENQ;
			end else begin
				case ($urandom_range(3))
					0: op = OP_PEEK_HEAD;
					1: op = OP_PEEK_TAIL;
					default: op = OP_DEQ;
				endcase
			end
			send_request(op, random_word());
			// sender pause until every response is back
			if ($urandom_range(79) == 0)
				wait_quiet();
		end
	endtask

	// capacities across the whole register range, the clamped ones included
	task automatic test_capacity_sweep();
		int sweep_caps [12] = '{16, 1, 31, 17, 5, 0, 2, 7, 16, 3, 10, 12};
		foreach (sweep_caps[i])
			test_random_traffic(CapW'(sweep_caps[i]), 90);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		set_capacity(CapW'(8));
		no_idle = 1'b1;
		hold_request = 60;
		for (int i = 0; i < 40; i++)
			send_request(($urandom_range(99) < 60) ? OP_ENQ : OP_DEQ, random_word());
		no_idle = 1'b0;
	endtask

	// long run with no random gaps on either side, one transfer per cycle except during sender pauses
	task automatic test_full_rate();
		no_idle = 1'b1;
		test_random_traffic(CapW'(MaxDepth), 200);
		no_idle = 1'b0;
	endtask

	initial begin
		m_cap = CapW'(CapReset);
		clear_queue_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_reads();
		test_word_extremes();
		test_full_drop();
		test_capacity_clamp();
		test_capacity_sweep();
		test_backpressure();
		test_full_rate();

		wait_quiet();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("circular_fifo_queue_core test passed");
		else
			$display("circular_fifo_queue_core test failed");
		$finish;
	end

endmodule
